/* hdl/assert_macros.svh */
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)

`endif

`endif

/* hdl/cpet_pkg.sv */
`default_nettype none

package cpet_pkg;

  localparam int ID_W   = 6;
  localparam int SIZE_W = 16;
  localparam int HALF_W = 22;
  localparam int RAD_W  = HALF_W + 1;
  localparam int SQ_W   = 2 * RAD_W;
  localparam int EV_W   = 2;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_e;

  typedef enum logic {
    SHAPE_RECT   = 1'b0,
    SHAPE_CIRCLE = 1'b1
  } shape_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic finish;
  } cpet_cmd_t;

  function automatic logic [HALF_W-1:0] half_size(input logic [SIZE_W-1:0] size);
    half_size = HALF_W'(size) * HALF_W'(50);
  endfunction

endpackage

`default_nettype wire

/* hdl/collision_pair_event_tracker.sv */
`default_nettype none

// Channel  Dir  tdata (low bit up)                                    tuser
// s_axis   in   left_id, right_id, left_pos_x, left_pos_y,            left_shape,
//               right_pos_x, right_pos_y, left_size_x, left_size_y,   right_shape
//               right_size_x, right_size_y, zero fill
// m_axis   out  contact_event, touching, zero fill                    -
//
// An item goes through accept with contact row read, the squaring stage, then the
// compare, contact row write-back and load of the output register; the squaring
// and contact row read-modify-write need these steps; no item is accepted meanwhile.
// Reset clears the per-row valid bits at once; no clearing pass is needed.
// A finished word waits in the output register while the next word is accepted;
// the finish step stalls only while that register is still full.

module collision_pair_event_tracker
  import cpet_pkg::*;
#(
  parameter int MAX_COLLIDERS = 64,
  parameter int POS_WIDTH     = 24
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // left_id, right_id, left_pos_x, left_pos_y, right_pos_x, right_pos_y,
  // left_size_x, left_size_y, right_size_x, right_size_y, zero fill
  input  wire logic [((2*ID_W+4*POS_WIDTH+4*SIZE_W+7)/8)*8-1:0] s_axis_tdata,
  // left_shape, right_shape
  input  wire logic [1:0]                            s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // contact_event, touching, zero fill
  output logic [7:0]                                 m_axis_tdata
);

  localparam int LID_LO = 0;
  localparam int RID_LO = ID_W;
  localparam int LPX_LO = 2 * ID_W;
  localparam int LPY_LO = LPX_LO + POS_WIDTH;
  localparam int RPX_LO = LPY_LO + POS_WIDTH;
  localparam int RPY_LO = RPX_LO + POS_WIDTH;
  localparam int LSX_LO = RPY_LO + POS_WIDTH;
  localparam int LSY_LO = LSX_LO + SIZE_W;
  localparam int RSX_LO = LSY_LO + SIZE_W;
  localparam int RSY_LO = RSX_LO + SIZE_W;

  cpet_cmd_t       cmd;
  logic [EV_W-1:0] contact_event;
  logic            touching;

  cpet_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .cmd_o     (cmd)
  );

  cpet_dp #(
    .MAX_COLLIDERS(MAX_COLLIDERS),
    .POS_WIDTH    (POS_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .left_id_i      (s_axis_tdata[LID_LO +: ID_W]),
    .right_id_i     (s_axis_tdata[RID_LO +: ID_W]),
    .left_shape_i   (s_axis_tuser[0]),
    .right_shape_i  (s_axis_tuser[1]),
    .left_pos_x_i   (s_axis_tdata[LPX_LO +: POS_WIDTH]),
    .left_pos_y_i   (s_axis_tdata[LPY_LO +: POS_WIDTH]),
    .right_pos_x_i  (s_axis_tdata[RPX_LO +: POS_WIDTH]),
    .right_pos_y_i  (s_axis_tdata[RPY_LO +: POS_WIDTH]),
    .left_size_x_i  (s_axis_tdata[LSX_LO +: SIZE_W]),
    .left_size_y_i  (s_axis_tdata[LSY_LO +: SIZE_W]),
    .right_size_x_i (s_axis_tdata[RSX_LO +: SIZE_W]),
    .right_size_y_i (s_axis_tdata[RSY_LO +: SIZE_W]),
    .contact_event_o(contact_event),
    .touching_o     (touching)
  );

  assign m_axis_tdata = {5'd0, touching, contact_event};

endmodule

`default_nettype wire

/* hdl/cpet_store.sv */
`default_nettype none

module cpet_store
  import cpet_pkg::*;
#(
  parameter int ROW_AW = 6,
  parameter int ROW_W  = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [ROW_AW-1:0] rd_row_i,
  output logic      [ROW_W-1:0]  rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ROW_AW-1:0] wr_row_i,
  input  wire logic [ROW_W-1:0]  wr_data_i
);

  localparam int ROWS = 1 << ROW_AW;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid_q;
  logic [ROW_W-1:0] rd_data_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_row_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_row_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  // never-written rows read as no contact
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* hdl/cpet_dp.sv */
`default_nettype none

module cpet_dp
  import cpet_pkg::*;
#(
  parameter int MAX_COLLIDERS = 64,
  parameter int POS_WIDTH     = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cpet_cmd_t            cmd_i,
  input  wire logic [ID_W-1:0]      left_id_i,
  input  wire logic [ID_W-1:0]      right_id_i,
  input  wire logic                 left_shape_i,
  input  wire logic                 right_shape_i,
  input  wire logic [POS_WIDTH-1:0] left_pos_x_i,
  input  wire logic [POS_WIDTH-1:0] left_pos_y_i,
  input  wire logic [POS_WIDTH-1:0] right_pos_x_i,
  input  wire logic [POS_WIDTH-1:0] right_pos_y_i,
  input  wire logic [SIZE_W-1:0]    left_size_x_i,
  input  wire logic [SIZE_W-1:0]    left_size_y_i,
  input  wire logic [SIZE_W-1:0]    right_size_x_i,
  input  wire logic [SIZE_W-1:0]    right_size_y_i,
  output logic      [EV_W-1:0]      contact_event_o,
  output logic                      touching_o
);

  localparam int NUM_IDS = (MAX_COLLIDERS < (1 << ID_W)) ? MAX_COLLIDERS : (1 << ID_W);
  localparam int ID_AW   = $clog2(NUM_IDS);
  localparam int ROW_W   = 1 << ID_AW;
  localparam int CW      = ((POS_WIDTH > HALF_W) ? POS_WIDTH : HALF_W) + 2;
  localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(NUM_IDS);

  logic              is_rect;
  logic              is_circ;
  logic [HALF_W-1:0] lhx, lhy, rhx, rhy;
  logic [CW-1:0]     lcx, lcy, rcx, rcy;
  logic [CW:0]       diff_x, diff_y;
  logic [CW-1:0]     adx, ady;
  logic [RAD_W-1:0]  hx, hy;
  logic [CW-1:0]     hx_ext, hy_ext;
  logic              rect_hit, circ_near, keep;

  logic [ID_W-1:0]   lid_q, rid_q;
  logic              same_q, keep_q, rect_hit_q, circ_near_q;
  logic [RAD_W-1:0]  dx_q, dy_q, r_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q, rr_q;
  logic [SQ_W:0]     dist_sq;
  logic              touch, was;
  logic [ROW_W-1:0]  row_rd, row_wr;
  logic              wr_en;
  contact_event_e    ev;
  logic [EV_W-1:0]   ev_q;
  logic              touch_q;

  assign is_rect = (left_shape_i == SHAPE_RECT) && (right_shape_i == SHAPE_RECT);
  assign is_circ = (left_shape_i == SHAPE_CIRCLE) && (right_shape_i == SHAPE_CIRCLE);

  assign lhx = half_size(left_size_x_i);
  assign lhy = half_size(left_size_y_i);
  assign rhx = half_size(right_size_x_i);
  assign rhy = half_size(right_size_y_i);

  // circle centres sit at position plus half size; rectangles use position
  assign lcx = {{(CW-POS_WIDTH){left_pos_x_i[POS_WIDTH-1]}}, left_pos_x_i}
             + (is_circ ? {{(CW-HALF_W){1'b0}}, lhx} : '0);
  assign lcy = {{(CW-POS_WIDTH){left_pos_y_i[POS_WIDTH-1]}}, left_pos_y_i}
             + (is_circ ? {{(CW-HALF_W){1'b0}}, lhy} : '0);
  assign rcx = {{(CW-POS_WIDTH){right_pos_x_i[POS_WIDTH-1]}}, right_pos_x_i}
             + (is_circ ? {{(CW-HALF_W){1'b0}}, rhx} : '0);
  assign rcy = {{(CW-POS_WIDTH){right_pos_y_i[POS_WIDTH-1]}}, right_pos_y_i}
             + (is_circ ? {{(CW-HALF_W){1'b0}}, rhy} : '0);

  assign diff_x = {lcx[CW-1], lcx} - {rcx[CW-1], rcx};
  assign diff_y = {lcy[CW-1], lcy} - {rcy[CW-1], rcy};
  assign adx    = diff_x[CW] ? CW'((CW + 1)'(0) - diff_x) : diff_x[CW-1:0];
  assign ady    = diff_y[CW] ? CW'((CW + 1)'(0) - diff_y) : diff_y[CW-1:0];

  assign hx     = {1'b0, lhx} + {1'b0, rhx};
  assign hy     = {1'b0, lhy} + {1'b0, rhy};
  assign hx_ext = {{(CW-RAD_W){1'b0}}, hx};
  assign hy_ext = {{(CW-RAD_W){1'b0}}, hy};

  assign rect_hit  = is_rect && (adx < hx_ext) && (ady < hy_ext);
  assign circ_near = is_circ && (adx <= hx_ext) && (ady <= hx_ext);
  assign keep      = ({1'b0, left_id_i} < ID_LIMIT) && ({1'b0, right_id_i} < ID_LIMIT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lid_q       <= left_id_i;
      rid_q       <= right_id_i;
      same_q      <= left_id_i == right_id_i;
      keep_q      <= keep;
      rect_hit_q  <= rect_hit;
      circ_near_q <= circ_near;
      dx_q        <= adx[RAD_W-1:0];
      dy_q        <= ady[RAD_W-1:0];
      r_q         <= hx;
    end
    if (cmd_i.mul) begin
      sqx_q <= SQ_W'(dx_q) * SQ_W'(dx_q);
      sqy_q <= SQ_W'(dy_q) * SQ_W'(dy_q);
      rr_q  <= SQ_W'(r_q) * SQ_W'(r_q);
    end
    if (cmd_i.finish) begin
      ev_q    <= ev;
      touch_q <= touch;
    end
  end

  assign dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign touch   = !same_q && (rect_hit_q || (circ_near_q && (dist_sq <= {1'b0, rr_q})));
  assign was     = row_rd[rid_q[ID_AW-1:0]];

  always_comb begin
    ev = EV_NONE;
    if (!same_q && keep_q) begin
      if (touch) begin
        ev = was ? EV_STAY : EV_ENTER;
      end else if (was) begin
        ev = EV_EXIT;
      end
    end
  end

  always_comb begin
    row_wr = row_rd;
    row_wr[rid_q[ID_AW-1:0]] = touch;
  end

  assign wr_en = cmd_i.finish && keep_q && !same_q;

  cpet_store #(
    .ROW_AW(ID_AW),
    .ROW_W (ROW_W)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (cmd_i.load),
    .rd_row_i (left_id_i[ID_AW-1:0]),
    .rd_data_o(row_rd),
    .wr_en_i  (wr_en),
    .wr_row_i (lid_q[ID_AW-1:0]),
    .wr_data_i(row_wr)
  );

  assign contact_event_o = ev_q;
  assign touching_o      = touch_q;

endmodule

`default_nettype wire

/* hdl/cpet_ctrl.sv */
`default_nettype none

`include "assert_macros.svh"

module cpet_ctrl
  import cpet_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  wire logic m_tready_i,
  output cpet_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   out_free;

  assign out_free = !m_valid_q || m_tready_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    s_tready_o   = 1'b0;
    m_valid_d    = m_valid_q && !m_tready_i;
    case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the word
        if (out_free) begin
          cmd_o.finish = 1'b1;
          m_valid_d    = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_tvalid_o = m_valid_q;

  `ASSERT_CLK(a_load_then_mul, clk_i, rst_ni, cmd_o.load |=> cmd_o.mul, "load not followed by multiply")
  `ASSERT_CLK(a_mul_then_done, clk_i, rst_ni, cmd_o.mul |=> (state_q == S_DONE), "multiply not followed by done")
  `ASSERT_CLK(a_finish_valid, clk_i, rst_ni, cmd_o.finish |=> m_valid_q, "finished word not presented")
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.finish && m_valid_q && !m_tready_i, "pending word overwritten")

endmodule

`default_nettype wire

/* tb/contact_event_checker.sv */
`default_nettype none

module contact_event_checker
  import cpet_pkg::*;
#(
  parameter int MAX_COLLIDERS = 64,
  parameter int POS_WIDTH     = 24,
  parameter int IN_W          = 176
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  input  wire logic            s_axis_tready,
  input  wire logic [IN_W-1:0] s_axis_tdata,
  input  wire logic [1:0]      s_axis_tuser,
  input  wire logic            m_axis_tvalid,
  input  wire logic            m_axis_tready,
  input  wire logic [7:0]      m_axis_tdata,
  output int                   mismatches_o,
  output int                   pending_o
);

  localparam int OFS_RID = ID_W;
  localparam int OFS_LPX = 2 * ID_W;
  localparam int OFS_LPY = OFS_LPX + POS_WIDTH;
  localparam int OFS_RPX = OFS_LPY + POS_WIDTH;
  localparam int OFS_RPY = OFS_RPX + POS_WIDTH;
  localparam int OFS_LSX = OFS_RPY + POS_WIDTH;
  localparam int OFS_LSY = OFS_LSX + SIZE_W;
  localparam int OFS_RSX = OFS_LSY + SIZE_W;
  localparam int OFS_RSY = OFS_RSX + SIZE_W;

  typedef struct {
    logic [ID_W-1:0]             left_id;
    logic [ID_W-1:0]             right_id;
    shape_e                      left_shape;
    shape_e                      right_shape;
    logic signed [POS_WIDTH-1:0] left_pos_x;
    logic signed [POS_WIDTH-1:0] left_pos_y;
    logic signed [POS_WIDTH-1:0] right_pos_x;
    logic signed [POS_WIDTH-1:0] right_pos_y;
    logic [SIZE_W-1:0]           left_size_x;
    logic [SIZE_W-1:0]           left_size_y;
    logic [SIZE_W-1:0]           right_size_x;
    logic [SIZE_W-1:0]           right_size_y;
  } pair_item_t;

  typedef struct {
    contact_event_e kind;
    logic           touching;
  } contact_result_t;

  bit              contact_state [MAX_COLLIDERS*MAX_COLLIDERS];
  contact_result_t contact_results_due [$];
  contact_result_t want;
  int              fail_count = 0;

  function automatic pair_item_t unpack_pair(logic [IN_W-1:0] d, logic [1:0] u);
    pair_item_t p;
    p.left_id      = d[0 +: ID_W];
    p.right_id     = d[OFS_RID +: ID_W];
    p.left_shape   = shape_e'(u[0]);
    p.right_shape  = shape_e'(u[1]);
    p.left_pos_x   = d[OFS_LPX +: POS_WIDTH];
    p.left_pos_y   = d[OFS_LPY +: POS_WIDTH];
    p.right_pos_x  = d[OFS_RPX +: POS_WIDTH];
    p.right_pos_y  = d[OFS_RPY +: POS_WIDTH];
    p.left_size_x  = d[OFS_LSX +: SIZE_W];
    p.left_size_y  = d[OFS_LSY +: SIZE_W];
    p.right_size_x = d[OFS_RSX +: SIZE_W];
    p.right_size_y = d[OFS_RSY +: SIZE_W];
    return p;
  endfunction

  function automatic longint gap(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic rects_overlap(pair_item_t p);
    longint hx, hy;
    hx = 50 * (longint'(p.left_size_x) + longint'(p.right_size_x));
    hy = 50 * (longint'(p.left_size_y) + longint'(p.right_size_y));
    return gap(longint'(p.left_pos_x), longint'(p.right_pos_x)) < hx &&
           gap(longint'(p.left_pos_y), longint'(p.right_pos_y)) < hy;
  endfunction

  function automatic logic circles_overlap(pair_item_t p);
    longint lcx, lcy, rcx, rcy, rad, dx, dy;
    lcx = longint'(p.left_pos_x) + 50 * longint'(p.left_size_x);
    lcy = longint'(p.left_pos_y) + 50 * longint'(p.left_size_y);
    rcx = longint'(p.right_pos_x) + 50 * longint'(p.right_size_x);
    rcy = longint'(p.right_pos_y) + 50 * longint'(p.right_size_y);
    rad = 50 * (longint'(p.left_size_x) + longint'(p.right_size_x));
    dx  = gap(lcx, rcx);
    dy  = gap(lcy, rcy);
    if (dx > rad || dy > rad) return 1'b0;
    return dx * dx + dy * dy <= rad * rad;
  endfunction

  function automatic contact_result_t track_contact(pair_item_t p);
    contact_result_t r;
    int              idx;
    bit              was;
    r.kind     = EV_NONE;
    r.touching = 1'b0;
    if (p.left_id == p.right_id) return r;
    if (p.left_shape == SHAPE_RECT && p.right_shape == SHAPE_RECT) begin
      r.touching = rects_overlap(p);
    end else if (p.left_shape == SHAPE_CIRCLE && p.right_shape == SHAPE_CIRCLE) begin
      r.touching = circles_overlap(p);
    end
    if (int'(p.left_id) < MAX_COLLIDERS && int'(p.right_id) < MAX_COLLIDERS) begin
      idx = int'(p.left_id) * MAX_COLLIDERS + int'(p.right_id);
      was = contact_state[idx];
      if (r.touching) begin
        r.kind = was ? EV_STAY : EV_ENTER;
        contact_state[idx] = 1'b1;
      end else if (was) begin
        r.kind = EV_EXIT;
        contact_state[idx] = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_results_due.delete();
      foreach (contact_state[i]) contact_state[i] = 1'b0;
      pending_o    <= 0;
      mismatches_o <= fail_count;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (contact_results_due.size() == 0) begin
          $display("%0t: result word %h with nothing expected", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = contact_results_due.pop_front();
          if (m_axis_tdata[1:0] !== want.kind) begin
            $display("%0t: contact_event expected %0d (%s) actual %0d", $time,
                     want.kind, want.kind.name(), m_axis_tdata[1:0]);
            fail_count++;
          end
          if (m_axis_tdata[2] !== want.touching) begin
            $display("%0t: touching expected %0b actual %0b", $time,
                     want.touching, m_axis_tdata[2]);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        contact_results_due.push_back(track_contact(unpack_pair(s_axis_tdata, s_axis_tuser)));
      end
      pending_o    <= contact_results_due.size();
      mismatches_o <= fail_count;
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
  import cpet_pkg::*;

  localparam int POS_W     = 24;
  localparam int IN_W      = ((2*ID_W + 4*POS_W + 4*SIZE_W + 7) / 8) * 8;
  localparam int LONG_HOLD = 400;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata  = '0;
  logic [1:0]      s_axis_tuser  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;

  int mismatches;
  int pending;
  bit calm      = 1'b0;
  bit gaps_on   = 1'b1;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  collision_pair_event_tracker #(
    .MAX_COLLIDERS(64),
    .POS_WIDTH    (POS_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  contact_event_checker #(
    .MAX_COLLIDERS(64),
    .POS_WIDTH    (POS_W),
    .IN_W         (IN_W)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // result side: random stalls, one long hold-off on request, none when calm
  initial begin
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  task automatic offer_pair(
    input logic [ID_W-1:0]   lid,
    input logic [ID_W-1:0]   rid,
    input shape_e            ls,
    input shape_e            rs,
    input logic [POS_W-1:0]  lpx,
    input logic [POS_W-1:0]  lpy,
    input logic [POS_W-1:0]  rpx,
    input logic [POS_W-1:0]  rpy,
    input logic [SIZE_W-1:0] lsx,
    input logic [SIZE_W-1:0] lsy,
    input logic [SIZE_W-1:0] rsx,
    input logic [SIZE_W-1:0] rsy
  );
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({rsy, rsx, lsy, lsx, rpy, rpx, lpy, lpx, rid, lid});
    s_axis_tuser  <= {rs, ls};
    do @(posedge clk_i); while (!s_axis_tready);
    if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // drop valid and hold until every predicted word has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [ID_W-1:0] pool_id();
    return $urandom_range(0, 1) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom_range(60, 63));
  endfunction

  function automatic logic [SIZE_W-1:0] size_draw();
    return ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 800));
  endfunction

  function automatic int spread(int h);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? h : -h;
    return int'($urandom_range(0, 3 * h)) - (3 * h) / 2;
  endfunction

  task automatic offer_random_pair();
    logic [ID_W-1:0]   lid, rid;
    shape_e            ls, rs;
    logic [SIZE_W-1:0] lsx, lsy, rsx, rsy;
    int                pick, hx, hy, lpx, lpy, rpx, rpy;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      offer_pair(ID_W'($urandom), ID_W'($urandom), shape_e'(1'($urandom)),
                 shape_e'(1'($urandom)), POS_W'($urandom), POS_W'($urandom),
                 POS_W'($urandom), POS_W'($urandom), SIZE_W'($urandom),
                 SIZE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
      return;
    end
    lid = pool_id();
    rid = pool_id();
    ls  = shape_e'(1'($urandom_range(0, 1)));
    rs  = ls;
    if (pick == 2) rs = (ls == SHAPE_RECT) ? SHAPE_CIRCLE : SHAPE_RECT;
    lsx = size_draw();
    lsy = size_draw();
    rsx = size_draw();
    rsy = size_draw();
    hx  = 50 * (int'(lsx) + int'(rsx));
    hy  = (ls == SHAPE_CIRCLE) ? hx : 50 * (int'(lsy) + int'(rsy));
    lpx = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
    lpy = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
    rpx = lpx + spread(hx);
    rpy = lpy + spread(hy);
    if (ls == SHAPE_CIRCLE) begin
      // place the centers, not the corners, at the drawn distance
      rpx += 50 * (int'(lsx) - int'(rsx));
      rpy += 50 * (int'(lsy) - int'(rsy));
    end
    offer_pair(lid, rid, ls, rs, POS_W'(lpx), POS_W'(lpy), POS_W'(rpx), POS_W'(rpy),
               lsx, lsy, rsx, rsy);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_pair(1, 2, SHAPE_RECT, SHAPE_RECT, 0, 0, 10, 10, 1, 1, 1, 1);
    offer_pair(1, 2, SHAPE_RECT, SHAPE_RECT, 0, 0, POS_W'(-50), 20, 1, 1, 1, 1);
    offer_pair(1, 2, SHAPE_RECT, SHAPE_RECT, 0, 0, 5000, 0, 1, 1, 1, 1);
    offer_pair(1, 2, SHAPE_RECT, SHAPE_RECT, 0, 0, 5000, 0, 1, 1, 1, 1);
    offer_pair(5, 5, SHAPE_RECT, SHAPE_RECT, 0, 0, 0, 0, 9, 9, 9, 9);
    offer_pair(1, 2, SHAPE_RECT, SHAPE_RECT, 0, 0, 100, 0, 1, 1, 1, 1);
    offer_pair(1, 2, SHAPE_RECT, SHAPE_RECT, 0, 0, 99, POS_W'(-99), 1, 1, 1, 1);
    offer_pair(1, 2, SHAPE_RECT, SHAPE_CIRCLE, 0, 0, 0, 0, 4, 4, 4, 4);
    offer_pair(2, 1, SHAPE_CIRCLE, SHAPE_CIRCLE, 0, 0, 200, 0, 2, 0, 2, 0);
    offer_pair(2, 1, SHAPE_CIRCLE, SHAPE_CIRCLE, 0, 0, 120, 160, 2, 0, 2, 0);
    offer_pair(2, 1, SHAPE_CIRCLE, SHAPE_CIRCLE, 0, 0, 120, 161, 2, 0, 2, 0);
    offer_pair(2, 1, SHAPE_CIRCLE, SHAPE_CIRCLE, 0, 0, 201, 0, 2, 0, 2, 0);
    offer_pair(0, 63, SHAPE_CIRCLE, SHAPE_CIRCLE, 77, 77, 77, 77, 0, 0, 0, 0);
    offer_pair(63, 0, SHAPE_RECT, SHAPE_RECT, 77, 77, 77, 77, 0, 0, 0, 0);
    offer_pair(0, 63, SHAPE_RECT, SHAPE_RECT, 24'h800000, 24'h800000,
               24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer_pair(63, 0, SHAPE_RECT, SHAPE_RECT, 24'h7FFFFF, 24'h800000,
               24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer_pair(63, 0, SHAPE_CIRCLE, SHAPE_CIRCLE, 24'h800000, 24'h800000,
               24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer_pair(62, 61, SHAPE_CIRCLE, SHAPE_CIRCLE, 24'h7FFFFF, 24'h7FFFFF,
               24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer_pair(62, 61, SHAPE_CIRCLE, SHAPE_RECT, 24'h7FFFFF, 24'h7FFFFF,
               24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer_pair(63, 63, SHAPE_CIRCLE, SHAPE_CIRCLE, 24'hFFFFFF, 24'hFFFFFF,
               24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_drained();

    repeat (400) offer_random_pair();
    wait_drained();

    // stall the result side while words keep coming
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (30) offer_random_pair();
    gaps_on  = 1'b1;

    repeat (400) offer_random_pair();
    wait_drained();

    calm = 1'b1;
    repeat (320) offer_random_pair();

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(4 * 400000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+hdl
hdl/cpet_pkg.sv
hdl/cpet_store.sv
hdl/cpet_dp.sv
hdl/cpet_ctrl.sv
hdl/collision_pair_event_tracker.sv
tb/contact_event_checker.sv
tb/testbench.sv
